@@ src/kcr_pkg.sv @@
// kcr_pkg: shared types, constants and helpers of the keyframe color ramp.
`timescale 1ns / 1ps

package kcr_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_SEGMENTS = 64;
  localparam int DEF_FRAC_BITS    = 16;

  // Fixed geometry of a path segment and of the fixed-point state.
  localparam int WPS     = 7;   // words per segment
  localparam int WORD_W  = 16;
  localparam int ACC_W   = 26;
  localparam int CFG_W   = 8;
  localparam int CIDX_W  = 2;
  localparam int SS_W    = 6;
  localparam int LOOP_W  = 8;
  localparam int SF_W    = 8;
  localparam int WIDX_W  = 9;
  localparam int DELTA_W = 16;
  localparam int LVL_W   = 8;

  localparam logic signed [63:0] ACC_MAX = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
  localparam logic signed [63:0] ACC_MIN = -(64'sd1 <<< (ACC_W - 1));

  // Input word modes.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_LOOP_COUNT     = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_START_SEGMENT  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_START_FRACTION = 2'd2;

  typedef struct packed {
    logic                     mode;
    logic [WIDX_W-1:0]        word_index;
    logic signed [WORD_W-1:0] word_value;
    logic [DELTA_W-1:0]       delta_time;
    logic                     hold_color;
  } kcr_in_word_t;

  typedef struct packed {
    logic [LVL_W-1:0] red;
    logic [LVL_W-1:0] green;
    logic [LVL_W-1:0] blue;
    logic             color_valid;
    logic             finished;
  } kcr_out_word_t;

  typedef struct packed {
    logic [CIDX_W-1:0] index;
    logic [CFG_W-1:0]  value;
  } kcr_cfg_word_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TICK,
    ST_CHECK,
    ST_LD_ADDR,
    ST_LD_RANGE,
    ST_LD_MARK,
    ST_LD_END,
    ST_LD_RD,
    ST_LD_CAP,
    ST_LD_SET,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FRAC,
    ST_MV_MUL,
    ST_MV_ADD,
    ST_MV_TIME,
    ST_EMIT,
    ST_FINISH
  } kcr_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic       ram_wr;       // write path word from the input port
    logic       cap_in;       // latch delta and hold of a tick
    logic       tick_init;    // first tick after reset or a register write
    logic       ld_addr;      // form the next segment address
    logic       rd_en;        // read path word at segment address + word_ofs
    logic       cap_word;     // capture read data into segment word word_ofs
    logic [2:0] word_ofs;
    logic       ld_wrap;      // end marker: count a pass, go to segment 0
    logic       ld_set;       // load colors and time from captured segment
    logic       div_start;
    logic       div_store;
    logic [1:0] chan;         // color channel for divide and move
    logic       frac_mul;     // elapsed time of the start fraction
    logic       mv_mul;
    logic       mv_add;
    logic       mv_time;
    logic       mv_use_e;     // move by start-fraction time, else by delta
    logic       emit;
    logic       emit_finish;
  } kcr_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic finished;
    logic started;
    logic frac_nonzero;
    logic time_nonpos;
    logic end_range;
    logic mark_neg;
    logic loops_is_one;
    logic dur_zero;
    logic div_done;
    logic div_busy;
    logic out_free;
    logic hold;
  } kcr_sts_t;

  // Clamp to the signed accumulator range.
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [63:0] x);
    if (x > ACC_MAX) begin
      sat_acc = ACC_W'(ACC_MAX);
    end else if (x < ACC_MIN) begin
      sat_acc = ACC_W'(ACC_MIN);
    end else begin
      sat_acc = ACC_W'(x);
    end
  endfunction

endpackage

@@ src/kcr_stream_if.sv @@
// kcr_stream_if: valid/ready channel carrying one payload word.
`timescale 1ns / 1ps

interface kcr_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ src/keyframe_color_ramp.sv @@
// keyframe_color_ramp: top level of the piecewise linear light color ramp.
// A path word write completes in its accept cycle. A tick without a segment change passes
// check, emit and, unless hold is set, the color move; the color word is registered on emit.
// A segment change adds path table reads and one pass of the shared restoring divider
// per channel; a nonzero start fraction adds the fraction multiply and a color move.
// rst_n (synchronous, active low) clears ramp state and config registers; path table is not cleared.
`timescale 1ns / 1ps

module keyframe_color_ramp #(
  parameter int MAX_SEGMENTS = kcr_pkg::DEF_MAX_SEGMENTS,
  parameter int FRAC_BITS    = kcr_pkg::DEF_FRAC_BITS
) (
  input logic          clk,
  input logic          rst_n,
  kcr_stream_if.sink   in_ch,
  kcr_stream_if.source out_ch,
  kcr_stream_if.sink   cfg_ch
);
  import kcr_pkg::*;

  kcr_cmd_t      cmd;
  kcr_sts_t      sts;
  logic          in_ready;
  logic          out_valid;
  kcr_out_word_t out_word;

  // The controller takes one word at a time: a path write finishes in the
  // accept cycle, a tick walks through check, optional segment load, emit
  // and, unless hold is set, color move before ready returns. The output
  // word has its own register, so a new word is taken while a result waits.
  kcr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.payload.mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // State, path table, slope divider and the multipliers live here.
  // Register writes land directly; the user must send them only while the ramp is idle, unenforced here.
  kcr_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_word   (in_ch.payload),
    .cfg_we    (cfg_ch.valid),
    .cfg_word  (cfg_ch.payload),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  // Hold the input until the controller is idle; take register writes at once.
  assign in_ch.ready    = in_ready;
  assign cfg_ch.ready   = 1'b1;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_word;
endmodule

@@ src/kcr_ram.sv @@
// kcr_ram: generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module kcr_ram #(
  parameter int WIDTH = kcr_pkg::WORD_W,
  parameter int DEPTH = kcr_pkg::DEF_MAX_SEGMENTS * kcr_pkg::WPS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

@@ src/kcr_div.sv @@
// kcr_div: iterative signed restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module kcr_div #(
  parameter int NUM_W = kcr_pkg::WORD_W + 1 + kcr_pkg::DEF_FRAC_BITS,
  parameter int DEN_W = kcr_pkg::WORD_W
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [NUM_W-1:0]             num,
  input  logic signed [DEN_W-1:0]             den,
  output logic                                busy,
  output logic                                done,
  output logic signed [kcr_pkg::ACC_W-1:0]    quo
);
  import kcr_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             neg_r, neg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;

  logic [DEN_W:0]          trial;
  logic signed [DEN_W:0]   den_ext;
  logic [63:0]             mag64;
  logic signed [63:0]      sval;

  assign den_ext = (DEN_W+1)'(den);
  assign trial   = {rem_r, q_r[NUM_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      neg_nxt  = num[NUM_W-1] ^ den[DEN_W-1];
      q_nxt    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      den_nxt  = den_ext[DEN_W] ? DEN_W'(-den_ext) : DEN_W'(den_ext);
    end else if (busy_r) begin
      // Shift in the next dividend bit, subtract where it fits.
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DEN_W'(trial - {1'b0, den_r});
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = DEN_W'(trial);
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  // Apply sign, clamp to the accumulator range.
  assign mag64 = 64'(q_r);
  assign sval  = neg_r ? -$signed(mag64) : $signed(mag64);
  assign quo   = sat_acc(sval);
  assign busy  = busy_r;
  assign done  = done_r;
endmodule

@@ src/kcr_datapath.sv @@
// kcr_datapath: ramp state, path table, divider and multiplier of the color ramp.
`timescale 1ns / 1ps

module kcr_datapath #(
  parameter int MAX_SEGMENTS = kcr_pkg::DEF_MAX_SEGMENTS,
  parameter int FRAC_BITS    = kcr_pkg::DEF_FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  kcr_pkg::kcr_cmd_t      cmd,
  output kcr_pkg::kcr_sts_t      sts,
  input  kcr_pkg::kcr_in_word_t  in_word,
  input  logic                   cfg_we,
  input  kcr_pkg::kcr_cfg_word_t cfg_word,
  input  logic                   out_ready,
  output logic                   out_valid,
  output kcr_pkg::kcr_out_word_t out_word
);
  import kcr_pkg::*;

  localparam int TW    = MAX_SEGMENTS * WPS;
  localparam int AW    = $clog2(TW);
  localparam int CW    = $clog2(TW + 512);
  localparam int NUM_W = WORD_W + 1 + FRAC_BITS;

  logic [LOOP_W-1:0] lc_r, lc_nxt;
  logic [SS_W-1:0]   ss_r, ss_nxt;
  logic [SF_W-1:0]   sf_r, sf_nxt;
  logic              started_r, started_nxt;
  logic              first_load_r, first_load_nxt;
  logic              finished_r, finished_nxt;
  logic [LOOP_W-1:0] loops_r, loops_nxt;
  logic [AW-1:0]     rec_r, rec_nxt;
  logic [CW-1:0]     cur_addr_r, cur_addr_nxt;

  logic signed [ACC_W-1:0]   acc_r [3];
  logic signed [ACC_W-1:0]   acc_nxt [3];
  logic signed [ACC_W-1:0]   step_r [3];
  logic signed [ACC_W-1:0]   step_nxt [3];
  logic signed [ACC_W-1:0]   time_r, time_nxt;
  logic signed [ACC_W-1:0]   e_r, e_nxt;
  logic signed [2*ACC_W-1:0] prod_r, prod_nxt;
  logic signed [WORD_W-1:0]  wd_r [WPS];
  logic signed [WORD_W-1:0]  wd_nxt [WPS];
  logic [DELTA_W-1:0]        delta_r, delta_nxt;
  logic                      hold_r, hold_nxt;
  logic                      out_valid_r, out_valid_nxt;
  kcr_out_word_t             out_word_r, out_word_nxt;

  logic [WORD_W-1:0]         ram_q;
  logic                      ram_we;
  logic [CW-1:0]             widx_ext;
  logic [AW-1:0]             ram_raddr;

  logic signed [ACC_W-1:0]   mv_b;
  logic signed [ACC_W+SF_W:0] fprod;
  logic signed [WORD_W-1:0]  div_lo, div_hi;
  logic signed [WORD_W:0]    div_diff;
  logic signed [NUM_W-1:0]   div_num;
  logic signed [ACC_W-1:0]   div_quo;
  logic                      div_busy, div_done;

  function automatic logic [LVL_W-1:0] level(input logic signed [ACC_W-1:0] a);
    logic [ACC_W-1:0] v;
    v = ACC_W'(a >>> FRAC_BITS);
    if (a < 0) begin
      level = '0;
    end else if (v > ACC_W'(255)) begin
      level = '1;
    end else begin
      level = v[LVL_W-1:0];
    end
  endfunction

  // Path table.
  assign widx_ext  = CW'(in_word.word_index);
  assign ram_we    = cmd.ram_wr && (widx_ext < CW'(TW));
  assign ram_raddr = cur_addr_r[AW-1:0] + AW'(cmd.word_ofs);

  kcr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TW)
  ) u_path_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (widx_ext[AW-1:0]),
    .wdata (in_word.word_value),
    .re    (cmd.rd_en),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // Slope divider: ((end - start) << FRAC_BITS) / duration.
  always_comb begin
    case (cmd.chan)
      2'd1: begin
        div_lo = wd_r[1];
        div_hi = wd_r[4];
      end
      2'd2: begin
        div_lo = wd_r[2];
        div_hi = wd_r[5];
      end
      default: begin
        div_lo = wd_r[0];
        div_hi = wd_r[3];
      end
    endcase
  end

  assign div_diff = (WORD_W+1)'(div_hi) - (WORD_W+1)'(div_lo);
  assign div_num  = NUM_W'(div_diff) <<< FRAC_BITS;

  kcr_div #(
    .NUM_W (NUM_W),
    .DEN_W (WORD_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (wd_r[WPS-1]),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign mv_b  = cmd.mv_use_e ? e_r : $signed(ACC_W'(delta_r));
  assign fprod = time_r * $signed({1'b0, sf_r});

  always_comb begin
    lc_nxt         = lc_r;
    ss_nxt         = ss_r;
    sf_nxt         = sf_r;
    started_nxt    = started_r;
    first_load_nxt = first_load_r;
    finished_nxt   = finished_r;
    loops_nxt      = loops_r;
    rec_nxt        = rec_r;
    cur_addr_nxt   = cur_addr_r;
    acc_nxt        = acc_r;
    step_nxt       = step_r;
    time_nxt       = time_r;
    e_nxt          = e_r;
    prod_nxt       = prod_r;
    wd_nxt         = wd_r;
    delta_nxt      = delta_r;
    hold_nxt       = hold_r;
    out_valid_nxt  = out_valid_r;
    out_word_nxt   = out_word_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.cap_in) begin
      delta_nxt = in_word.delta_time;
      hold_nxt  = in_word.hold_color;
    end

    if (cmd.tick_init) begin
      started_nxt    = 1'b1;
      loops_nxt      = lc_r;
      first_load_nxt = 1'b1;
      time_nxt       = '0;
    end

    if (cmd.ld_addr) begin
      cur_addr_nxt   = first_load_r ? CW'(ss_r) * CW'(WPS) : CW'(rec_r) + CW'(WPS);
      first_load_nxt = 1'b0;
    end

    if (cmd.ld_wrap) begin
      if (loops_r > LOOP_W'(1)) begin
        loops_nxt = loops_r - LOOP_W'(1);
      end
      cur_addr_nxt = '0;
    end

    if (cmd.cap_word) begin
      wd_nxt[cmd.word_ofs] = $signed(ram_q);
    end

    if (cmd.ld_set) begin
      rec_nxt  = cur_addr_r[AW-1:0];
      for (int c = 0; c < 3; c++) begin
        acc_nxt[c] = sat_acc(64'(wd_r[c]) <<< FRAC_BITS);
      end
      time_nxt = ACC_W'(wd_r[WPS-1]);
    end

    if (cmd.div_store) begin
      step_nxt[cmd.chan] = div_quo;
    end

    if (cmd.frac_mul) begin
      // Floor of time * fraction / 256.
      e_nxt = fprod[ACC_W+SF_W-1:SF_W];
    end

    if (cmd.mv_mul) begin
      prod_nxt = step_r[cmd.chan] * mv_b;
    end

    if (cmd.mv_add) begin
      acc_nxt[cmd.chan] = sat_acc(64'(acc_r[cmd.chan]) + 64'(prod_r));
    end

    if (cmd.mv_time) begin
      time_nxt = sat_acc(64'(time_r) - 64'(mv_b));
    end

    if (cmd.emit) begin
      out_valid_nxt            = 1'b1;
      out_word_nxt.red         = level(acc_r[0]);
      out_word_nxt.green       = level(acc_r[1]);
      out_word_nxt.blue        = level(acc_r[2]);
      out_word_nxt.color_valid = !hold_r;
      out_word_nxt.finished    = 1'b0;
    end

    if (cmd.emit_finish) begin
      out_valid_nxt            = 1'b1;
      out_word_nxt.red         = '0;
      out_word_nxt.green       = '0;
      out_word_nxt.blue        = '0;
      out_word_nxt.color_valid = 1'b0;
      out_word_nxt.finished    = 1'b1;
      finished_nxt             = 1'b1;
    end

    if (cfg_we) begin
      unique case (cfg_word.index)
        CFG_LOOP_COUNT: begin
          lc_nxt       = cfg_word.value;
          started_nxt  = 1'b0;
          finished_nxt = 1'b0;
        end
        CFG_START_SEGMENT: begin
          ss_nxt       = cfg_word.value[SS_W-1:0];
          started_nxt  = 1'b0;
          finished_nxt = 1'b0;
        end
        CFG_START_FRACTION: begin
          sf_nxt       = cfg_word.value;
          started_nxt  = 1'b0;
          finished_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lc_r         <= '0;
      ss_r         <= '0;
      sf_r         <= '0;
      started_r    <= 1'b0;
      first_load_r <= 1'b0;
      finished_r   <= 1'b0;
      loops_r      <= '0;
      rec_r        <= '0;
      for (int c = 0; c < 3; c++) begin
        acc_r[c]  <= '0;
        step_r[c] <= '0;
      end
      time_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      lc_r         <= lc_nxt;
      ss_r         <= ss_nxt;
      sf_r         <= sf_nxt;
      started_r    <= started_nxt;
      first_load_r <= first_load_nxt;
      finished_r   <= finished_nxt;
      loops_r      <= loops_nxt;
      rec_r        <= rec_nxt;
      acc_r        <= acc_nxt;
      step_r       <= step_nxt;
      time_r       <= time_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    cur_addr_r <= cur_addr_nxt;
    e_r        <= e_nxt;
    prod_r     <= prod_nxt;
    wd_r       <= wd_nxt;
    delta_r    <= delta_nxt;
    hold_r     <= hold_nxt;
    out_word_r <= out_word_nxt;
  end

  assign sts.finished     = finished_r;
  assign sts.started      = started_r;
  assign sts.frac_nonzero = (sf_r != '0);
  assign sts.time_nonpos  = (time_r <= 0);
  assign sts.end_range    = ((CW+1)'(cur_addr_r) + (CW+1)'(WPS)) > (CW+1)'(TW);
  assign sts.mark_neg     = ram_q[WORD_W-1];
  assign sts.loops_is_one = (loops_r == LOOP_W'(1));
  assign sts.dur_zero     = (wd_r[WPS-1] == '0);
  assign sts.div_done     = div_done;
  assign sts.div_busy     = div_busy;
  assign sts.out_free     = !out_valid_r || out_ready;
  assign sts.hold         = hold_r;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.emit_finish) |-> (!out_valid_r || out_ready))
    else $error("result written over an untaken word");

  a_seg_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_set |-> (((CW+1)'(cur_addr_r) + (CW+1)'(WPS)) <= (CW+1)'(TW)))
    else $error("segment loaded beyond the path table");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_finish_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.finished) |->
      (!out_word_r.color_valid && out_word_r.red == '0 &&
       out_word_r.green == '0 && out_word_r.blue == '0))
    else $error("finished word carries a color");
`endif
endmodule

@@ src/kcr_ctrl.sv @@
// kcr_ctrl: sequencer of the color ramp, one input word at a time.
`timescale 1ns / 1ps

module kcr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_mode,
  output logic              in_ready,
  input  kcr_pkg::kcr_sts_t sts,
  output kcr_pkg::kcr_cmd_t cmd
);
  import kcr_pkg::*;

  kcr_state_t state_r, state_nxt;
  logic [1:0] chan_r, chan_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       use_e_r, use_e_nxt;
  logic       start_ld_r, start_ld_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      chan_r     <= '0;
      cnt_r      <= '0;
      use_e_r    <= 1'b0;
      start_ld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      chan_r     <= chan_nxt;
      cnt_r      <= cnt_nxt;
      use_e_r    <= use_e_nxt;
      start_ld_r <= start_ld_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    chan_nxt     = chan_r;
    cnt_nxt      = cnt_r;
    use_e_nxt    = use_e_r;
    start_ld_nxt = start_ld_r;
    cmd          = '0;
    cmd.chan     = chan_r;
    cmd.word_ofs = cnt_r;
    cmd.mv_use_e = use_e_r;
    in_ready     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode == MODE_TICK) begin
            cmd.cap_in = 1'b1;
            state_nxt  = ST_TICK;
          end else begin
            cmd.ram_wr = 1'b1;
          end
        end
      end
      ST_TICK: begin
        if (sts.finished) begin
          state_nxt = ST_FINISH;
        end else if (!sts.started) begin
          cmd.tick_init = 1'b1;
          if (sts.frac_nonzero) begin
            start_ld_nxt = 1'b1;
            state_nxt    = ST_LD_ADDR;
          end else begin
            state_nxt = ST_CHECK;
          end
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.time_nonpos) begin
          start_ld_nxt = 1'b0;
          state_nxt    = ST_LD_ADDR;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_LD_ADDR: begin
        cmd.ld_addr = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = ST_LD_RANGE;
      end
      ST_LD_RANGE: begin
        if (sts.end_range) begin
          state_nxt = ST_LD_END;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = ST_LD_MARK;
        end
      end
      ST_LD_MARK: begin
        state_nxt = sts.mark_neg ? ST_LD_END : ST_LD_RD;
      end
      ST_LD_END: begin
        if (sts.loops_is_one) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.ld_wrap = 1'b1;
          state_nxt   = ST_LD_RD;
        end
      end
      ST_LD_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_LD_CAP;
      end
      ST_LD_CAP: begin
        cmd.cap_word = 1'b1;
        if (cnt_r == 3'(WPS - 1)) begin
          state_nxt = ST_LD_SET;
        end else begin
          cnt_nxt   = cnt_r + 3'd1;
          state_nxt = ST_LD_RD;
        end
      end
      ST_LD_SET: begin
        cmd.ld_set = 1'b1;
        if (sts.dur_zero) begin
          state_nxt = start_ld_r ? ST_FRAC : ST_EMIT;
        end else begin
          chan_nxt  = '0;
          state_nxt = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          if (chan_r == 2'd2) begin
            state_nxt = start_ld_r ? ST_FRAC : ST_EMIT;
          end else begin
            chan_nxt  = chan_r + 2'd1;
            state_nxt = ST_DIV_GO;
          end
        end
      end
      ST_FRAC: begin
        cmd.frac_mul = 1'b1;
        use_e_nxt    = 1'b1;
        chan_nxt     = '0;
        state_nxt    = ST_MV_MUL;
      end
      ST_MV_MUL: begin
        cmd.mv_mul = 1'b1;
        state_nxt  = ST_MV_ADD;
      end
      ST_MV_ADD: begin
        cmd.mv_add = 1'b1;
        if (chan_r == 2'd2) begin
          state_nxt = ST_MV_TIME;
        end else begin
          chan_nxt  = chan_r + 2'd1;
          state_nxt = ST_MV_MUL;
        end
      end
      ST_MV_TIME: begin
        cmd.mv_time = 1'b1;
        state_nxt   = use_e_r ? ST_CHECK : ST_IDLE;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.hold) begin
            state_nxt = ST_IDLE;
          end else begin
            use_e_nxt = 1'b0;
            chan_nxt  = '0;
            state_nxt = ST_MV_MUL;
          end
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.emit_finish = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end
endmodule
